// ----- rtl/arp_cache_and_responder_top_defines.svh -----
// assertion macros for the arp cache and responder checker
// no dependencies; included by files that carry assertions
`ifndef ARP_CACHE_AND_RESPONDER_TOP_DEFINES_SVH
`define ARP_CACHE_AND_RESPONDER_TOP_DEFINES_SVH

// plain property, checked at every rising edge outside reset
`define ARPC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// same-cycle implication
`define ARPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/arpc_pkg.sv -----
// shared types and constants of the arp cache and responder
// no dependencies; imported by every module of the block
`default_nettype none

package arpc_pkg;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;
	localparam int ST_W  = 3;

	// stream word widths
	localparam int IN_TDATA_W  = 200;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_TUSER_W = ST_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 2'd2;

	// arp header constants
	localparam logic [15:0] HW_ETHER   = 16'h0001;
	localparam logic [15:0] PT_IPV4    = 16'h0800;
	localparam logic [15:0] OP_REQUEST = 16'h0001;

	// result status codes
	localparam logic [ST_W-1:0] ST_IGNORED = 3'd0;
	localparam logic [ST_W-1:0] ST_LEARNED = 3'd1;
	localparam logic [ST_W-1:0] ST_REPLY   = 3'd2;
	localparam logic [ST_W-1:0] ST_HIT     = 3'd3;
	localparam logic [ST_W-1:0] ST_MISS    = 3'd4;
	localparam logic [ST_W-1:0] ST_NOTRDY  = 3'd5;

	// item kind carried in tuser
	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic load;
		logic scan_en;
		logic wr_en;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic is_lookup;
		logic scan_done;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/arpc_ctrl.sv -----
// controller state machine of the arp cache and responder
// depends on arpc_pkg; drives the datapath through cmd_t, reads sts_t
`default_nettype none

module arpc_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_tvalid,
	output logic              in_tready,
	output logic              out_tvalid,
	input  wire logic         out_tready,
	input  wire arpc_pkg::sts_t sts,
	output arpc_pkg::cmd_t    cmd
);
	import arpc_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DISP  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_WRITE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       done_d;
	logic       out_vld_q;
	logic       out_free;

	assign out_free   = !out_vld_q || out_tready;
	assign in_tready  = (state_q == S_IDLE) && !done_q;
	assign out_tvalid = out_vld_q;

	always_comb begin
		state_d      = state_q;
		done_d       = done_q;
		cmd          = '0;
		cmd.load     = in_tvalid && in_tready;
		// a finished result waits here until the output register frees up
		cmd.res_load = done_q && out_free;
		if (cmd.res_load) begin
			done_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.need_scan) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) begin
					if (sts.is_lookup) begin
						state_d = S_IDLE;
						done_d  = 1'b1;
					end else begin
						state_d = S_WRITE;
					end
				end
			end
			S_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = S_IDLE;
				done_d    = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (out_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/arpc_dp.sv -----
// datapath of the arp cache and responder: config, item registers,
// table memory, compare scan and result register; depends on arpc_pkg
`default_nettype none

module arpc_dp #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [arpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [arpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic [arpc_pkg::IN_TDATA_W-1:0]  in_tdata,
	input  wire logic [arpc_pkg::IN_TUSER_W-1:0]  in_tuser,
	output logic      [arpc_pkg::OUT_TDATA_W-1:0] out_tdata,
	output logic      [arpc_pkg::OUT_TUSER_W-1:0] out_tuser,
	input  wire arpc_pkg::cmd_t                   cmd,
	output arpc_pkg::sts_t                        sts
);
	import arpc_pkg::*;

	localparam int IDXW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CW   = $clog2(CACHE_ENTRIES + 1);
	localparam logic [CW-1:0] LAST = CW'(CACHE_ENTRIES);

	// input word fields
	logic             f_short;
	logic [15:0]      f_hw;
	logic [15:0]      f_pt;
	logic [15:0]      f_op;
	logic [MAC_W-1:0] f_smac;
	logic [IP_W-1:0]  f_sip;
	logic [IP_W-1:0]  f_tip;
	logic [IP_W-1:0]  f_qip;

	assign f_short = in_tdata[0];
	assign f_hw    = in_tdata[16:1];
	assign f_pt    = in_tdata[32:17];
	assign f_op    = in_tdata[48:33];
	assign f_smac  = in_tdata[96:49];
	assign f_sip   = in_tdata[128:97];
	assign f_tip   = in_tdata[160:129];
	assign f_qip   = in_tdata[192:161];

	logic [IP_W-1:0]  local_ip_q;
	logic             enabled_q;

	logic             is_lookup_q;
	logic             learn_q;
	logic             reply_q;
	logic [IP_W-1:0]  key_q;
	logic [MAC_W-1:0] smac_q;

	logic [IP_W-1:0]  ip_mem  [CACHE_ENTRIES];
	logic [MAC_W-1:0] mac_mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	logic [CW-1:0]    issue_q;
	logic             issuing;
	logic             vld_s1;
	logic [IDXW-1:0]  idx_s1;
	logic [IP_W-1:0]  rd_ip_s1;
	logic [MAC_W-1:0] rd_mac_s1;
	logic             hit_q;
	logic [IDXW-1:0]  hit_idx_q;
	logic [MAC_W-1:0] hit_mac_q;
	logic             free_q;
	logic [IDXW-1:0]  free_idx_q;
	logic [IDXW-1:0]  wr_idx;

	logic [ST_W-1:0]  res_status;
	logic [MAC_W-1:0] res_mac;
	logic [IP_W-1:0]  res_ip;
	logic [ST_W-1:0]  status_q;
	logic [MAC_W-1:0] peer_mac_q;
	logic [IP_W-1:0]  peer_ip_q;

	// configuration; the local mac is only the reply source of the frame
	// builder and changes no result here, so no copy of it is kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
			enabled_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCAL_IP: local_ip_q <= cfg_wdata[IP_W-1:0];
				REG_ENABLED:  enabled_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// item capture; the key is the sender ip for a packet, the query ip for a lookup
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_lookup_q <= (in_tuser[0] == KIND_LOOKUP);
			learn_q     <= !f_short && (f_hw == HW_ETHER) && (f_pt == PT_IPV4);
			reply_q     <= (f_op == OP_REQUEST) && (f_tip == local_ip_q);
			key_q       <= (in_tuser[0] == KIND_LOOKUP) ? f_qip : f_sip;
			smac_q      <= f_smac;
		end
	end

	assign issuing = cmd.scan_en && (issue_q != LAST);
	assign wr_idx  = hit_q ? hit_idx_q : (free_q ? free_idx_q : '0);

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			ip_mem[wr_idx]  <= key_q;
			mac_mem[wr_idx] <= smac_q;
		end
		if (issuing) begin
			rd_ip_s1  <= ip_mem[issue_q[IDXW-1:0]];
			rd_mac_s1 <= mac_mem[issue_q[IDXW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// compare scan, one entry a cycle; keeps the first match and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_mac_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else if (cmd.load) begin
			issue_q <= '0;
			vld_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.scan_en) begin
			vld_s1 <= issuing;
			if (issuing) begin
				issue_q <= issue_q + 1'b1;
				idx_s1  <= issue_q[IDXW-1:0];
			end
			if (vld_s1 && valid_q[idx_s1] && (rd_ip_s1 == key_q) && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_mac_q <= rd_mac_s1;
			end
			if (vld_s1 && !valid_q[idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
	end

	assign sts.need_scan = is_lookup_q ? enabled_q : learn_q;
	assign sts.is_lookup = is_lookup_q;
	assign sts.scan_done = (issue_q == LAST) && !vld_s1;

	always_comb begin
		res_status = ST_IGNORED;
		res_mac    = '0;
		res_ip     = '0;
		if (is_lookup_q) begin
			if (!enabled_q) begin
				res_status = ST_NOTRDY;
			end else if (hit_q) begin
				res_status = ST_HIT;
				res_mac    = hit_mac_q;
			end else begin
				res_status = ST_MISS;
				res_ip     = key_q;
			end
		end else if (learn_q) begin
			if (reply_q) begin
				res_status = ST_REPLY;
				res_mac    = smac_q;
				res_ip     = key_q;
			end else begin
				res_status = ST_LEARNED;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q   <= res_status;
			peer_mac_q <= res_mac;
			peer_ip_q  <= res_ip;
		end
	end

	assign out_tdata = {peer_ip_q, peer_mac_q};
	assign out_tuser = status_q;

endmodule

`default_nettype wire

// ----- rtl/arp_cache_and_responder_top.sv -----
// channel   | dir | handshake                      | contents
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | arp header fields or lookup address
// m_axis    | out | m_axis_tvalid / m_axis_tready  | status, peer mac, peer ip
// cfg       | in  | cfg_we (no wait)               | local_ip, local_mac, enabled
//
// a dropped packet or a lookup while disabled skips the compare scan after dispatch
// a lookup while enabled or a learned packet runs the compare scan that reads one table
// entry per cycle; a learned packet adds one write-back
// one item at a time; the next word is taken the cycle after a result enters m_axis
// a stalled m_axis holds the result, a further finished result then blocks s_axis
// reset clears the valid bits of all entries at once, no clearing pass
// top level of the arp cache and responder; depends on arpc_pkg, arpc_ctrl, arpc_dp
`default_nettype none

module arp_cache_and_responder_top #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// short_packet, hw_type, ptype, opcode, src_mac, src_ip,
	// dst_ip, query_ip, zero pad
	input  wire logic [arpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// req_type
	input  wire logic [arpc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// peer_mac, peer_ip
	output logic      [arpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// status
	output logic      [arpc_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
	import arpc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	arpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	arpc_dp #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ----- rtl/arpc_checker.sv -----
// port-level checks of the arp cache and responder, bound to the top level
// depends on arpc_pkg and arp_cache_and_responder_top_defines.svh
`default_nettype none
`include "arp_cache_and_responder_top_defines.svh"

module arpc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [arpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic [arpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import arpc_pkg::*;

	// status never above the not-ready code
	`ARPC_ASSERT_IMP(a_status_range, clk, arst_n, m_axis_tvalid, (m_axis_tuser <= ST_NOTRDY), "status code out of range")

	// results without a peer carry an all-zero word
	`ARPC_ASSERT_IMP(a_zero_peer, clk, arst_n, m_axis_tvalid && (m_axis_tuser == ST_IGNORED || m_axis_tuser == ST_LEARNED || m_axis_tuser == ST_NOTRDY), (m_axis_tdata == '0), "peer fields not zero")

	// one item at a time: ready drops right after a word is taken
	`ARPC_ASSERT_NEXT(a_one_item, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")

	// stalled result holds
	`ARPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind arp_cache_and_responder_top arpc_checker u_arpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
